[sv/xor_checked_frame_deframer_macros.svh]
// Assertion macros used by the frame deframer checker.
`ifndef XOR_CHECKED_FRAME_DEFRAMER_MACROS_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_MACROS_SVH

// Implication in the same cycle, checked on aclk, off while aresetn is low.
`define XCFD_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("xcfd assertion failed");

// Implication in the next cycle, checked on aclk, off while aresetn is low.
`define XCFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("xcfd assertion failed");

`endif

[sv/xcfd_pkg.sv]
// Package: frame layout constants, register codes and result type of the deframer.
`default_nettype none

package xcfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int SPEED_W     = 16;
    localparam int FRAME_BYTES = 11;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int CFG_INDEX_W = 2;

    // Byte offsets inside a frame
    localparam logic [POS_W-1:0] FLAG_POS   = POS_W'(1);
    localparam logic [POS_W-1:0] STATUS_POS = POS_W'(2);
    localparam logic [POS_W-1:0] X_HI_POS   = POS_W'(3);
    localparam logic [POS_W-1:0] X_LO_POS   = POS_W'(4);
    localparam logic [POS_W-1:0] Y_HI_POS   = POS_W'(5);
    localparam logic [POS_W-1:0] Y_LO_POS   = POS_W'(6);
    localparam logic [POS_W-1:0] Z_HI_POS   = POS_W'(7);
    localparam logic [POS_W-1:0] Z_LO_POS   = POS_W'(8);
    localparam logic [POS_W-1:0] CHECK_POS  = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] TAIL_POS   = POS_W'(FRAME_BYTES - 1);

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h7B;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h7D;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER_BYTE = 2'd0,
        CFG_TAIL_BYTE   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                      ok;
        logic [BYTE_W-1:0]         flag_value;
        logic [BYTE_W-1:0]         status_value;
        logic signed [SPEED_W-1:0] x_speed;
        logic signed [SPEED_W-1:0] y_speed;
        logic signed [SPEED_W-1:0] z_speed;
    } frame_result_t;

endpackage

`default_nettype wire

[sv/xcfd_frame_parser.sv]
// Frame parser: hunts for the header, collects the frame body and checks tail and XOR.
`default_nettype none

module xcfd_frame_parser (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         byte_go,
    input  wire logic [xcfd_pkg::BYTE_W-1:0]  byte_data,
    input  wire logic [xcfd_pkg::BYTE_W-1:0]  header_byte,
    input  wire logic [xcfd_pkg::BYTE_W-1:0]  tail_byte,
    output logic                              frame_done,
    output xcfd_pkg::frame_result_t           frame
);
    import xcfd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] body_reg [FLAG_POS:CHECK_POS];

    always_comb begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        frame_done = 1'b0;
        if (byte_go) begin
            if (pos_reg == '0) begin
                // idle: drop anything but the header
                if (byte_data == header_byte) begin
                    pos_next = FLAG_POS;
                    xor_next = byte_data;
                end
            end else if (pos_reg == TAIL_POS) begin
                pos_next   = '0;
                frame_done = 1'b1;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < CHECK_POS) begin
                    xor_next = xor_reg ^ byte_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            xor_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_go && pos_reg != '0 && pos_reg <= CHECK_POS) begin
            body_reg[pos_reg] <= byte_data;
        end
    end

    always_comb begin
        frame.ok           = (byte_data == tail_byte) && (xor_reg == body_reg[CHECK_POS]);
        frame.flag_value   = body_reg[FLAG_POS];
        frame.status_value = body_reg[STATUS_POS];
        frame.x_speed      = $signed({body_reg[X_HI_POS], body_reg[X_LO_POS]});
        frame.y_speed      = $signed({body_reg[Y_HI_POS], body_reg[Y_LO_POS]});
        frame.z_speed      = $signed({body_reg[Z_HI_POS], body_reg[Z_LO_POS]});
    end

endmodule

`default_nettype wire

[sv/xor_checked_frame_deframer.sv]
// Top level: serial byte deframer with tail and XOR block check.
`default_nettype none

// The deframer takes one received byte per word on the s_ channel. While idle
// it drops every byte until one equals header_byte, then collects an 11-byte
// frame: header, flag, status, X, Y and Z speeds (big-endian signed 16 bit),
// an XOR check byte and a tail byte. A header value inside a frame is plain
// data. When the eleventh byte arrives one word goes out on the m_ channel:
// frame_ok is 1 when the tail equals tail_byte and the XOR of bytes 0 to 8
// equals the check byte; only then are the held flag, status and speeds
// replaced, otherwise the word repeats the previous values (zero after reset).
// Bytes that do not finish a frame produce no output word. Throughput is one
// byte per clock unless the output stalls: a byte is held in the input
// register, then the parser updates its position counter and running XOR,
// and a finishing byte loads the output register at that same edge, from
// which the result shows on m_. The input register only stalls while a
// finished result waits in the output register and m_ready is low.
// header_byte (index 0) and tail_byte (index 1) are written through the cfg
// port, which is always ready; other indexes are ignored. Write them only
// while no frame is in flight.

module xor_checked_frame_deframer (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // byte input
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [xcfd_pkg::BYTE_W-1:0]          s_rx_byte,
    // frame result
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_frame_ok,
    output logic [xcfd_pkg::BYTE_W-1:0]               m_flag_value,
    output logic [xcfd_pkg::BYTE_W-1:0]               m_status_value,
    output logic signed [xcfd_pkg::SPEED_W-1:0]       m_x_speed,
    output logic signed [xcfd_pkg::SPEED_W-1:0]       m_y_speed,
    output logic signed [xcfd_pkg::SPEED_W-1:0]       m_z_speed,
    // register writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [xcfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [xcfd_pkg::BYTE_W-1:0]          cfg_data
);
    import xcfd_pkg::*;

    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] tail_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              out_valid_reg;
    frame_result_t     out_reg;

    logic              proc_go;
    logic              frame_done;
    frame_result_t     frame;

    // Register writes: always taken, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            tail_reg   <= TAIL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HEADER_BYTE: header_reg <= cfg_data;
                CFG_TAIL_BYTE:   tail_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Process the held byte unless a finished result is stuck at the output
    assign proc_go = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    xcfd_frame_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_go     (proc_go),
        .byte_data   (in_byte_reg),
        .header_byte (header_reg),
        .tail_byte   (tail_reg),
        .frame_done  (frame_done),
        .frame       (frame)
    );

    // Output register doubles as the held values: advance only on a good frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            if (proc_go && frame_done) begin
                out_valid_reg <= 1'b1;
                out_reg.ok    <= frame.ok;
                if (frame.ok) begin
                    out_reg.flag_value   <= frame.flag_value;
                    out_reg.status_value <= frame.status_value;
                    out_reg.x_speed      <= frame.x_speed;
                    out_reg.y_speed      <= frame.y_speed;
                    out_reg.z_speed      <= frame.z_speed;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_ok     = out_reg.ok;
    assign m_flag_value   = out_reg.flag_value;
    assign m_status_value = out_reg.status_value;
    assign m_x_speed      = out_reg.x_speed;
    assign m_y_speed      = out_reg.y_speed;
    assign m_z_speed      = out_reg.z_speed;

endmodule

`default_nettype wire

[sv/xcfd_checker.sv]
// Port-level checker for the frame deframer, bound to the top level.
`default_nettype none

`include "xor_checked_frame_deframer_macros.svh"

module xcfd_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic                               m_frame_ok,
    input wire logic [xcfd_pkg::BYTE_W-1:0]        m_flag_value,
    input wire logic [xcfd_pkg::BYTE_W-1:0]        m_status_value,
    input wire logic signed [xcfd_pkg::SPEED_W-1:0] m_x_speed,
    input wire logic signed [xcfd_pkg::SPEED_W-1:0] m_y_speed,
    input wire logic signed [xcfd_pkg::SPEED_W-1:0] m_z_speed
);

    // m_valid rises after the finishing byte is accepted and passes the input and output registers
    `XCFD_ASSERT(a_result_after_byte, $rose(m_valid), $past(s_valid && s_ready, 2))

    // Input backpressure only while a result is stalled at the output
    `XCFD_ASSERT(a_ready_only_stalls_on_output, !s_ready, m_valid && !m_ready)

    // A stalled result holds
    `XCFD_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_frame_ok) && $stable(m_flag_value) && $stable(m_status_value) && $stable(m_x_speed) && $stable(m_y_speed) && $stable(m_z_speed))

endmodule

bind xor_checked_frame_deframer xcfd_checker u_xcfd_checker (.*);

`default_nettype wire
